>>> hdl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define VRT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vrt assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define VRT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vrt assertion failed");

`endif

>>> hdl/vrt_pkg.sv
`timescale 1ns / 1ps

package vrt_pkg;

	// Stream payload layout, lowest bit first.
	localparam int IN_W     = 160;
	localparam int OUT_W    = 32;
	localparam int CX_LSB   = 0;
	localparam int CY_LSB   = 6;
	localparam int CZ_LSB   = 12;
	localparam int CV_LSB   = 18;
	localparam int OX_LSB   = 26;
	localparam int OY_LSB   = 50;
	localparam int OZ_LSB   = 74;
	localparam int DX_LSB   = 98;
	localparam int DY_LSB   = 118;
	localparam int DZ_LSB   = 138;
	localparam int CELL_W   = 6;
	localparam int VAL_W    = 8;
	localparam int ORG_W    = 24;
	localparam int DIR_W    = 20;
	localparam int FRAC_W   = 16;

	// Configuration.
	localparam int MAXD_W = 23;
	localparam logic [MAXD_W-1:0] MAXD_RESET = 23'd524288;

	// Datapath widths.
	localparam int L2_W    = 40;
	localparam int V_W     = 64;
	localparam int LENS_W  = 32;
	localparam int REM_W   = 35;
	localparam int DIST_W  = 17;
	localparam int DVN_W   = 49;
	localparam int DVD_W   = 32;
	localparam int TW      = 39;
	localparam int CUR_W   = 11;
	localparam int NRM_W   = 2;
	localparam logic [TW-1:0] T_NEVER = '1;
	localparam logic [NRM_W-1:0] NRM_POS = 2'b01;
	localparam logic [NRM_W-1:0] NRM_NEG = 2'b11;

	// Sequencer counts.
	localparam logic [5:0] LEN_LAST  = 6'd2;
	localparam logic [5:0] ROOT_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST  = 6'd48;
	localparam logic [2:0] SEL_LAST  = 3'd5;

	// Item kinds.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CAST  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEN,
		ST_LCHK,
		ST_ROOT,
		ST_DIVLD,
		ST_DIV,
		ST_DIVST,
		ST_WALK,
		ST_READ,
		ST_EVAL,
		ST_FIN
	} vrt_state_t;

	typedef struct packed {
		logic       load;
		logic       wr;
		logic       clr;
		logic       sq_acc;
		logic [1:0] axis;
		logic       kind_tdel;
		logic       sq_init;
		logic       sq_iter;
		logic       div_load;
		logic       div_iter;
		logic       div_store;
		logic       walk_init;
		logic       rd;
		logic       step;
		logic       mark_hit;
		logic       fin_load;
	} vrt_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic l2_zero;
		logic maxd_zero;
		logic solid;
		logic go_on;
	} vrt_sts_t;

endpackage

>>> hdl/vrt_ram.sv
`timescale 1ns / 1ps

module vrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/vrt_datapath.sv
`timescale 1ns / 1ps

module vrt_datapath #(
	parameter int GRID_SIZE = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [vrt_pkg::IN_W-1:0]  s_tdata,
	input  logic                      cfg_we,
	input  logic [vrt_pkg::MAXD_W-1:0] cfg_wdata,
	input  vrt_pkg::vrt_cmd_t         cmd,
	output vrt_pkg::vrt_sts_t         sts,
	output logic [vrt_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_hit
);

	import vrt_pkg::*;

	localparam int DEPTH  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [MAXD_W-1:0] maxd_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_done_q;

	logic signed [CUR_W-1:0] cur_q [3];
	logic [FRAC_W-1:0]       frac_q [3];
	logic                    neg_q [3];
	logic [DIR_W-1:0]        mag_q [3];
	logic [TW-1:0]           tmax_q [3];
	logic [TW-1:0]           tdel_q [3];
	logic [L2_W-1:0]         l2_q;
	logic [V_W-1:0]          v_q;
	logic [REM_W-1:0]        rem_q;
	logic [LENS_W-1:0]       root_q;
	logic [DVN_W-1:0]        dn_q;
	logic [DVD_W-1:0]        dr_q;
	logic [DVD_W-1:0]        dd_q;
	logic [1:0]              axis_q;
	logic                    found_q;
	logic                    rd_inrange_q;
	logic                    hit_q;
	logic [7:0]              hx_q, hy_q, hz_q;
	logic [NRM_W-1:0]        nrm_q [3];

	logic [CELL_W-1:0] wx, wy, wz;
	logic [VAL_W-1:0]  wval;
	logic              w_inrange;
	logic [ADDR_W-1:0] waddr, raddr, ram_waddr;
	logic [VAL_W-1:0]  ram_wdata, rdata;
	logic              ram_we;
	logic              r_inrange;
	logic [1:0]        a_sel, ix;
	logic [DIR_W-1:0]  mag_ix;
	logic [TW-1:0]     tmax_ix;
	logic [L2_W-1:0]   sq;
	logic [REM_W-1:0]  rem_sh, trial;
	logic [DIST_W-1:0] dist_ix;
	logic [DVN_W-1:0]  prod;
	logic [DVD_W:0]    dv_sh, dv_diff;
	logic              dv_ge;

	// Write item fields and grid address.
	assign wx   = s_tdata[CX_LSB +: CELL_W];
	assign wy   = s_tdata[CY_LSB +: CELL_W];
	assign wz   = s_tdata[CZ_LSB +: CELL_W];
	assign wval = s_tdata[CV_LSB +: VAL_W];
	assign w_inrange = (32'(wx) < GRID_SIZE) && (32'(wy) < GRID_SIZE) &&
		(32'(wz) < GRID_SIZE);
	assign waddr = ADDR_W'((32'(wx) * GRID_SIZE + 32'(wy)) * GRID_SIZE + 32'(wz));

	// Current voxel address; cells outside the grid read as air.
	assign r_inrange = !cur_q[0][CUR_W-1] && !cur_q[1][CUR_W-1] && !cur_q[2][CUR_W-1] &&
		(32'(cur_q[0][CUR_W-2:0]) < GRID_SIZE) &&
		(32'(cur_q[1][CUR_W-2:0]) < GRID_SIZE) &&
		(32'(cur_q[2][CUR_W-2:0]) < GRID_SIZE);
	assign raddr = ADDR_W'((32'(cur_q[0][CUR_W-2:0]) * GRID_SIZE +
		32'(cur_q[1][CUR_W-2:0])) * GRID_SIZE + 32'(cur_q[2][CUR_W-2:0]));

	// The clearing sweep owns the write port until it finishes.
	assign ram_we    = cmd.clr || (cmd.wr && w_inrange);
	assign ram_waddr = cmd.clr ? clr_addr_q : waddr;
	assign ram_wdata = cmd.clr ? '0 : wval;

	vrt_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Axis choice: x only if strictly smallest, else y if below z, else z.
	always_comb begin
		if ((tmax_q[0] < tmax_q[1]) && (tmax_q[0] < tmax_q[2])) begin
			a_sel = 2'd0;
		end else if (!(tmax_q[0] < tmax_q[1]) && (tmax_q[1] < tmax_q[2])) begin
			a_sel = 2'd1;
		end else begin
			a_sel = 2'd2;
		end
	end

	// One shared axis index for the per-axis registers.
	assign ix      = cmd.step ? a_sel : (cmd.fin_load ? axis_q : cmd.axis);
	assign mag_ix  = mag_q[ix];
	assign tmax_ix = tmax_q[ix];
	assign dist_ix = neg_q[ix] ? {1'b0, frac_q[ix]} : (17'd65536 - {1'b0, frac_q[ix]});
	assign sq      = L2_W'(mag_ix * mag_ix);
	assign prod    = DVN_W'(dist_ix * root_q);

	// Root step: two radicand bits per cycle.
	assign rem_sh = {rem_q[REM_W-3:0], v_q[V_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});

	// Divide step: one quotient bit per cycle.
	assign dv_sh   = {dr_q, dn_q[DVN_W-1]};
	assign dv_diff = dv_sh - {1'b0, dd_q};
	assign dv_ge   = dv_sh >= {1'b0, dd_q};

	assign sts.clr_done  = clr_done_q;
	assign sts.l2_zero   = (l2_q == '0);
	assign sts.maxd_zero = (maxd_q == '0);
	assign sts.solid     = rd_inrange_q && (rdata != '0);
	assign sts.go_on     = tmax_ix < TW'(maxd_q);

	// Configuration register and clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxd_q     <= MAXD_RESET;
			clr_addr_q <= '0;
			clr_done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				maxd_q <= cfg_wdata;
			end
			if (cmd.clr) begin
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					clr_done_q <= 1'b1;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
		end
	end

	// Ray setup, root, division and walk registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				logic [ORG_W-1:0] o;
				logic [DIR_W-1:0] d;
				o = s_tdata[OX_LSB + i * ORG_W +: ORG_W];
				d = s_tdata[DX_LSB + i * DIR_W +: DIR_W];
				cur_q[i]  <= {{(CUR_W - 8){o[ORG_W-1]}}, o[ORG_W-1 -: 8]};
				frac_q[i] <= o[FRAC_W-1:0];
				neg_q[i]  <= d[DIR_W-1];
				mag_q[i]  <= d[DIR_W-1] ? (~d + 1'b1) : d;
			end
			l2_q    <= '0;
			found_q <= 1'b0;
		end
		if (cmd.sq_acc) begin
			l2_q <= l2_q + sq;
		end
		if (cmd.sq_init) begin
			v_q    <= {l2_q, 24'd0};
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.sq_iter) begin
			v_q <= {v_q[V_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[LENS_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[LENS_W-2:0], 1'b0};
			end
		end
		if (cmd.div_load) begin
			dr_q <= '0;
			if (cmd.kind_tdel) begin
				dn_q <= DVN_W'({root_q, 4'b0000});
				dd_q <= DVD_W'(mag_ix);
			end else begin
				dn_q <= prod;
				dd_q <= {mag_ix, 12'd0};
			end
		end
		if (cmd.div_iter) begin
			dn_q <= {dn_q[DVN_W-2:0], dv_ge};
			dr_q <= dv_ge ? dv_diff[DVD_W-1:0] : dv_sh[DVD_W-1:0];
		end
		if (cmd.div_store) begin
			if (cmd.kind_tdel) begin
				tdel_q[ix] <= (mag_ix == '0) ? '0 : dn_q[TW-1:0];
			end else begin
				tmax_q[ix] <= (mag_ix == '0) ? T_NEVER : dn_q[TW-1:0];
			end
		end
		if (cmd.walk_init) begin
			axis_q <= 2'd2;
		end
		if (cmd.rd) begin
			rd_inrange_q <= r_inrange;
		end
		if (cmd.step) begin
			cur_q[ix]  <= neg_q[ix] ? (cur_q[ix] - CUR_W'(1)) : (cur_q[ix] + CUR_W'(1));
			tmax_q[ix] <= tmax_ix + tdel_q[ix];
			axis_q     <= ix;
		end
		if (cmd.mark_hit) begin
			found_q <= 1'b1;
		end
	end

	// Result register; a miss reports all zeros.
	always_ff @(posedge clk) begin
		if (cmd.fin_load) begin
			hit_q <= found_q;
			hx_q  <= found_q ? cur_q[0][7:0] : '0;
			hy_q  <= found_q ? cur_q[1][7:0] : '0;
			hz_q  <= found_q ? cur_q[2][7:0] : '0;
			for (int i = 0; i < 3; i++) begin
				if (found_q && (ix == 2'(i))) begin
					nrm_q[i] <= neg_q[ix] ? NRM_POS : NRM_NEG;
				end else begin
					nrm_q[i] <= '0;
				end
			end
		end
	end

	assign m_hit   = hit_q;
	assign m_tdata = {2'b00, nrm_q[2], nrm_q[1], nrm_q[0], hz_q, hy_q, hx_q};

endmodule

>>> hdl/vrt_ctrl.sv
`timescale 1ns / 1ps

module vrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_func,
	output logic              s_tready,
	input  logic              m_tready,
	output logic              m_tvalid,
	input  vrt_pkg::vrt_sts_t sts,
	output vrt_pkg::vrt_cmd_t cmd
);

	import vrt_pkg::*;

	vrt_state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [2:0] sel_q, sel_d;
	logic       out_valid_q;

	// State, counters and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
			if (cmd.fin_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		sel_d         = sel_q;
		cmd           = '0;
		cmd.axis      = sel_q[2:1];
		cmd.kind_tdel = sel_q[0];
		s_tready      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = !sts.clr_done;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_func == FUNC_CAST) begin
						cmd.load = 1'b1;
						cnt_d    = '0;
						state_d  = ST_LEN;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_LEN: begin
				cmd.sq_acc = 1'b1;
				cmd.axis   = cnt_q[1:0];
				if (cnt_q == LEN_LAST) begin
					state_d = ST_LCHK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_LCHK: begin
				if (sts.l2_zero) begin
					state_d = ST_FIN;
				end else begin
					cmd.sq_init = 1'b1;
					cnt_d       = '0;
					state_d     = ST_ROOT;
				end
			end
			ST_ROOT: begin
				cmd.sq_iter = 1'b1;
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == ROOT_LAST) begin
					sel_d   = '0;
					state_d = ST_DIVLD;
				end
			end
			ST_DIVLD: begin
				cmd.div_load = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_iter = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_DIVST;
				end
			end
			ST_DIVST: begin
				cmd.div_store = 1'b1;
				if (sel_q == SEL_LAST) begin
					state_d = ST_WALK;
				end else begin
					sel_d   = sel_q + 1'b1;
					state_d = ST_DIVLD;
				end
			end
			ST_WALK: begin
				cmd.walk_init = 1'b1;
				state_d = sts.maxd_zero ? ST_FIN : ST_READ;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.solid) begin
					cmd.mark_hit = 1'b1;
					state_d      = ST_FIN;
				end else begin
					cmd.step = 1'b1;
					state_d  = sts.go_on ? ST_READ : ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					cmd.fin_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/voxel_ray_traversal.sv
`timescale 1ns / 1ps

// Voxel ray traversal over a cubic grid of 8-bit block ids.
// Input stream (s_*): s_tuser selects the kind of beat: 0 writes one cell,
// 1 casts a ray. A write beat leaves the input ready. A cast beat returns
// exactly one result beat on the m_* stream: m_tuser is the hit flag and
// m_tdata carries the hit voxel and the entered face normal (zeros on a miss).
// A cast's setup is a two-bit-per-cycle square root and six restoring
// divisions sharing one unit; each voxel visited then costs one registered
// read of the grid memory and one evaluate step.
// Items are handled one at a time; a new beat is taken once the previous
// result sits in the output register, even while the receiver stalls.
// A stalled result holds until m_tready; the result of a later cast waits
// in the block until the output register empties.
// After reset the grid memory is cleared to air by a sweep over all GRID_SIZE^3
// cells (262144 at the default size); no beat is taken until it ends.
// cfg_we writes max_distance (unsigned Q7.16); keep writes to idle (unenforced).
module voxel_ray_traversal #(
	parameter int GRID_SIZE = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [vrt_pkg::MAXD_W-1:0]  cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// cell_x, cell_y, cell_z, cell_value, origin_x, origin_y, origin_z,
	// dir_x, dir_y, dir_z, two zero bits
	input  logic [vrt_pkg::IN_W-1:0]    s_tdata,
	// func
	input  logic [0:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, two zero bits
	output logic [vrt_pkg::OUT_W-1:0]   m_tdata,
	// hit
	output logic [0:0]                  m_tuser
);

	import vrt_pkg::*;

	vrt_cmd_t cmd;
	vrt_sts_t sts;

	vrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_func   (s_tuser[0]),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	vrt_datapath #(
		.GRID_SIZE (GRID_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata),
		.m_hit     (m_tuser[0])
	);

endmodule

>>> hdl/vrt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vrt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [0:0]                  s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [vrt_pkg::OUT_W-1:0]   m_tdata,
	input logic [0:0]                  m_tuser
);

	import vrt_pkg::*;

	logic [2:0] nrm_nz;

	assign nrm_nz = {m_tdata[29:28] != '0, m_tdata[27:26] != '0, m_tdata[25:24] != '0};

	// A stalled result beat holds its payload.
	`VRT_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A miss carries an all-zero payload.
	`VRT_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0)

	// A hit names exactly one face axis.
	`VRT_ASSERT_IMP(a_hit_face, m_tvalid && m_tuser[0], $countones(nrm_nz) == 1)

	// A cast beat keeps the input closed in the following cycle.
	`VRT_ASSERT_NXT(a_cast_busy, s_tvalid && s_tready && (s_tuser[0] == FUNC_CAST), !s_tready)

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (.*);

>>> tb/tb_voxel_ray_traversal.sv
`timescale 1ns / 1ps

module tb_voxel_ray_traversal;
	import vrt_pkg::*;

	localparam int GRID      = 64;
	localparam int CYCLE_CAP = 8000000;

	typedef struct packed {
		logic       hit;
		logic [31:0] data;
	} ray_hit_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [MAXD_W-1:0] cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic [0:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic [0:0]        m_tuser;

	// Shadow copy of the grid and the distance limit.
	logic [7:0]        grid_copy [GRID*GRID*GRID];
	logic [MAXD_W-1:0] maxd_copy;
	ray_hit_t          pending_hits [$];

	int  send_idle_pct;
	int  recv_idle_pct;
	int  recv_hold;
	int  errors;
	longint cycle_cnt;

	voxel_ray_traversal dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Walk one ray through the shadow grid with the DDA stepping rule.
	function automatic ray_hit_t trace_ray(input logic [IN_W-1:0] b);
		longint signed   dv [3];
		longint unsigned mg [3];
		longint unsigned tmx [3];
		longint unsigned tdl [3];
		longint unsigned l2, lens, reach, org, fr, v, r, bt;
		int              cur [3];
		int              stp [3];
		int              ax, a, i;
		ray_hit_t        res;
		res = '0;
		ax = -1;
		l2 = 0;
		for (i = 0; i < 3; i++) begin
			dv[i] = longint'($signed(b[DX_LSB + DIR_W*i +: DIR_W]));
			mg[i] = (dv[i] < 0) ? -dv[i] : dv[i];
			l2 += mg[i] * mg[i];
		end
		if (l2 == 0)
			return res;
		// Integer square root of the squared length scaled by 2^24.
		v = l2 << 24;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt >>= 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		lens = r;
		for (i = 0; i < 3; i++) begin
			org = b[OX_LSB + ORG_W*i +: ORG_W];
			fr = org & 64'hFFFF;
			cur[i] = int'($signed(org[23:16]));
			stp[i] = (dv[i] >= 0) ? 1 : -1;
			reach = (stp[i] > 0) ? (65536 - fr) : fr;
			if (mg[i] == 0) begin
				tmx[i] = '1;
				tdl[i] = 0;
			end else begin
				tmx[i] = (reach * lens) / (mg[i] << 12);
				tdl[i] = (lens << 4) / mg[i];
			end
		end
		reach = 0;
		while (reach < longint'(maxd_copy)) begin
			if (cur[0] >= 0 && cur[1] >= 0 && cur[2] >= 0 &&
			    cur[0] < GRID && cur[1] < GRID && cur[2] < GRID &&
			    grid_copy[(cur[0]*GRID + cur[1])*GRID + cur[2]] != 8'd0) begin
				res.hit = 1'b1;
				res.data[7:0]   = cur[0][7:0];
				res.data[15:8]  = cur[1][7:0];
				res.data[23:16] = cur[2][7:0];
				a = (ax < 0) ? 2 : ax;
				res.data[24 + 2*a +: 2] = 2'(-stp[a]);
				return res;
			end
			if (tmx[0] < tmx[1] && tmx[0] < tmx[2])
				a = 0;
			else if (!(tmx[0] < tmx[1]) && tmx[1] < tmx[2])
				a = 1;
			else
				a = 2;
			cur[a] += stp[a];
			reach = tmx[a];
			tmx[a] += tdl[a];
			ax = a;
		end
		return res;
	endfunction

	// Offer one beat and wait until it is taken, then update the shadow state.
	task automatic send_beat(input logic func, input logic [IN_W-1:0] payload);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = payload;
		s_tuser  = func;
		do
			@(posedge clk);
		while (!s_tready);
		if (func == FUNC_WRITE)
			grid_copy[(int'(payload[CX_LSB +: CELL_W])*GRID + int'(payload[CY_LSB +: CELL_W]))
				* GRID + int'(payload[CZ_LSB +: CELL_W])] = payload[CV_LSB +: VAL_W];
		else
			pending_hits.push_back(trace_ray(payload));
	endtask

	task automatic write_cell(input int x, input int y, input int z, input int val);
		logic [IN_W-1:0] p;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom};
		p[CX_LSB +: CELL_W] = CELL_W'(x);
		p[CY_LSB +: CELL_W] = CELL_W'(y);
		p[CZ_LSB +: CELL_W] = CELL_W'(z);
		p[CV_LSB +: VAL_W]  = VAL_W'(val);
		send_beat(FUNC_WRITE, p);
	endtask

	task automatic cast_ray(input int ox, input int oy, input int oz,
			input int dx, input int dy, input int dz);
		logic [IN_W-1:0] p;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom};
		p[OX_LSB +: ORG_W] = ORG_W'(ox);
		p[OY_LSB +: ORG_W] = ORG_W'(oy);
		p[OZ_LSB +: ORG_W] = ORG_W'(oz);
		p[DX_LSB +: DIR_W] = DIR_W'(dx);
		p[DY_LSB +: DIR_W] = DIR_W'(dy);
		p[DZ_LSB +: DIR_W] = DIR_W'(dz);
		p[IN_W-2 +: 2] = 2'b00;
		send_beat(FUNC_CAST, p);
	endtask

	// Wait for every result, let a trailing write settle, then update the limit.
	task automatic set_max_distance(input logic [MAXD_W-1:0] val);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we    = 1'b0;
		maxd_copy = val;
	endtask

	// Result side: random stalls or a long hold-off.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			m_tready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result beat with the oldest prediction.
	always @(posedge clk) begin
		ray_hit_t want;
		int f;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_hits.size() == 0) begin
				$display("%0t: unexpected result beat hit=%0d data=%h", $time, m_tuser, m_tdata);
				errors++;
			end else begin
				want = pending_hits.pop_front();
				if (m_tuser[0] !== want.hit) begin
					$display("%0t: hit expected %0d actual %0d", $time, want.hit, m_tuser);
					errors++;
				end
				for (f = 0; f < 6; f++) begin
					if (f < 3 && m_tdata[8*f +: 8] !== want.data[8*f +: 8]) begin
						$display("%0t: hit coord %0d expected %0d actual %0d", $time, f,
							$signed(want.data[8*f +: 8]), $signed(m_tdata[8*f +: 8]));
						errors++;
					end
					if (f >= 3 && m_tdata[24 + 2*(f-3) +: 2] !== want.data[24 + 2*(f-3) +: 2]) begin
						$display("%0t: normal %0d expected %0d actual %0d", $time, f - 3,
							$signed(want.data[24 + 2*(f-3) +: 2]),
							$signed(m_tdata[24 + 2*(f-3) +: 2]));
						errors++;
					end
				end
			end
		end
	end

	// Watchdog, long enough for the clearing sweep and the slowest walks.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Corner cells, solid start, axis ties, zero direction and extreme fields.
	task automatic test_directed();
		write_cell(0, 0, 0, 255);
		write_cell(63, 63, 63, 1);
		write_cell(10, 10, 10, 7);
		write_cell(12, 10, 10, 3);
		write_cell(3, 3, 3, 9);
		write_cell(3, 3, 3, 0);
		write_cell(4, 4, 4, 5);
		cast_ray(32'h8000, 32'h8000, 32'h8000, 0, 0, -65536);
		cast_ray(-(2 << 16), 32'h8000, 32'h8000, 65536, 0, 0);
		cast_ray((10 << 16) + 32'h8000, (10 << 16) + 32'h8000, (5 << 16), 0, 0, 65536);
		cast_ray((15 << 16), (10 << 16) + 32'h8000, (10 << 16) + 32'h8000, -65536, 0, 0);
		cast_ray((2 << 16) + 32'h8000, (2 << 16) + 32'h8000, (2 << 16) + 32'h8000,
			65536, 65536, 65536);
		cast_ray((2 << 16), (2 << 16), (2 << 16), 524287, 524287, 524287);
		cast_ray((20 << 16), (20 << 16), (20 << 16), 0, 0, 0);
		cast_ray(-8388608, -8388608, -8388608, 524287, 524287, 524287);
		cast_ray(8388607, 8388607, 8388607, -524288, -524288, -524288);
		cast_ray((66 << 16), (63 << 16) + 32'h8000, (63 << 16) + 32'h8000, -1, 0, 0);
		cast_ray((60 << 16), (60 << 16), (60 << 16), 1, 1, 1);
		set_max_distance('0);
		cast_ray((4 << 16), (4 << 16), (4 << 16), 65536, 0, 0);
		set_max_distance('1);
		cast_ray(-8388608, 0, 0, 524287, 3, -2);
		cast_ray((63 << 16) + 32'hFFFF, (30 << 16), (63 << 16), 1000, 524287, 7);
		set_max_distance(MAXD_RESET);
	endtask

	// Mostly rays through a populated block, with writes to keep it changing.
	task automatic test_random(input int count);
		int n, k;
		int org [3];
		int dir [3];
		for (n = 0; n < count; n++) begin
			k = $urandom_range(99);
			if (k < 35) begin
				write_cell($urandom_range(20, 43), $urandom_range(20, 43), $urandom_range(20, 43),
					($urandom_range(3) == 0) ? 0 : $urandom_range(1, 255));
			end else if (k < 40) begin
				write_cell($urandom_range(63), $urandom_range(63), $urandom_range(63), $urandom);
			end else begin
				for (int i = 0; i < 3; i++) begin
					if ($urandom_range(15) == 0)
						org[i] = int'($signed(24'($urandom)));
					else
						org[i] = ($urandom_range(72) - 6) * 65536 + $urandom_range(65535);
					case ($urandom_range(7))
						0: dir[i] = 0;
						1: dir[i] = int'($signed(20'($urandom)));
						2: dir[i] = $urandom_range(1, 300) * (($urandom_range(1) != 0) ? 1 : -1);
						default: dir[i] = int'($urandom_range(131072)) - 65536;
					endcase
				end
				cast_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2]);
			end
		end
	endtask

	// Hold the result side off long enough for the input to stall.
	task automatic test_backpressure();
		recv_hold = 4000;
		repeat (6)
			cast_ray((30 << 16), (30 << 16), (2 << 16), 500, -300, 65536);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		recv_hold = 0;
		errors = 0;
		cycle_cnt = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		maxd_copy = MAXD_RESET;
		foreach (grid_copy[i])
			grid_copy[i] = 8'd0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 11;
		recv_idle_pct = 53;
		test_directed();
		test_random(300);
		set_max_distance(23'h7FFFFF);
		send_idle_pct = 53;
		recv_idle_pct = 11;
		test_random(250);
		test_backpressure();
		set_max_distance(23'h2AAAAA);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(250);
		set_max_distance(23'($urandom_range(65536, 1 << 21)));
		test_random(200);

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/vrt_pkg.sv
hdl/vrt_ram.sv
hdl/vrt_datapath.sv
hdl/vrt_ctrl.sv
hdl/voxel_ray_traversal.sv
hdl/vrt_checker.sv
tb/tb_voxel_ray_traversal.sv
